// ===== src/srpd_pkg.sv =====
// Shared types and constants for the sensor reply packet deframer.
`timescale 1ns / 1ps

package srpd_pkg;

   // Result codes carried in the kind field
   typedef enum logic [2:0] {
      KIND_PAYLOAD    = 3'd0,
      KIND_GOOD       = 3'd1,
      KIND_BAD_START  = 3'd2,
      KIND_CHECKSUM   = 3'd3,
      KIND_TIMEOUT    = 3'd4,
      KIND_BAD_LENGTH = 3'd5
   } kind_type;

   // Input operation codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Register indexes (byte address bit 2)
   localparam logic REG_START_CODE = 1'b0;
   localparam logic REG_TIMEOUT    = 1'b1;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [15:0] START_CODE_RESET = 16'hEF01;
   localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;
   localparam logic [15:0] TICK_MAX         = 16'hFFFF;
   localparam logic [15:0] MIN_LENGTH       = 16'd2;

   // Header byte positions after the first start byte
   localparam logic [3:0] POS_SECOND = 4'd1;
   localparam logic [3:0] POS_TYPE   = 4'd6;
   localparam logic [3:0] POS_LEN_HI = 4'd7;
   localparam logic [3:0] POS_LEN_LO = 4'd8;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [7:0]  packet_type;
      logic [15:0] payload_length;
   } rsp_item_type;

endpackage

// ===== src/srpd_req_if.sv =====
// Input channel: received bytes and timer ticks.
`timescale 1ns / 1ps

interface srpd_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] byte_value;

   modport source (output valid, output operation, output byte_value, input ready);
   modport sink   (input valid, input operation, input byte_value, output ready);
endinterface

// ===== src/srpd_rsp_if.sv =====
// Result channel: payload bytes and frame status.
`timescale 1ns / 1ps

interface srpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  data_byte;
   logic [7:0]  packet_type;
   logic [15:0] payload_length;

   modport source (output valid, output kind, output data_byte, output packet_type,
                   output payload_length, input ready);
   modport sink   (input valid, input kind, input data_byte, input packet_type,
                   input payload_length, output ready);
endinterface

// ===== src/srpd_parser.sv =====
// Frame parser: phase tracking, running checksum and tick timeout.
`timescale 1ns / 1ps

module srpd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  operation,
   input  logic [7:0]            byte_value,
   input  logic [15:0]           start_code,
   input  logic [15:0]           timeout_ticks,
   output logic                  res_valid,
   output srpd_pkg::rsp_item_type res
);
   import srpd_pkg::*;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_CHECK   = 2'd3
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  hdr_idx_ff, hdr_idx_in;
   logic [15:0] remain_ff, remain_in;
   logic [15:0] plen_ff, plen_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  second_ff, second_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  cks_hi_ff, cks_hi_in;
   logic        cks_seen_ff, cks_seen_in;
   logic [15:0] tick_ff, tick_in;

   logic [15:0] tick_sat;
   logic [15:0] sum_add;
   logic [15:0] len_full;

   assign tick_sat = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + 16'd1;
   assign sum_add  = sum_ff + {8'h00, byte_value};
   assign len_full = {plen_ff[15:8], byte_value};

   always_comb begin
      phase_in    = phase_ff;
      hdr_idx_in  = hdr_idx_ff;
      remain_in   = remain_ff;
      plen_in     = plen_ff;
      sum_in      = sum_ff;
      second_in   = second_ff;
      type_in     = type_ff;
      cks_hi_in   = cks_hi_ff;
      cks_seen_in = cks_seen_ff;
      tick_in     = tick_ff;
      res_valid   = 1'b0;
      res         = '{kind: KIND_PAYLOAD, data_byte: 8'h00, packet_type: 8'h00,
                      payload_length: 16'h0000};

      if (accept && operation == OP_TICK) begin
         tick_in = tick_sat;
         if (timeout_ticks != 16'd0 && tick_sat >= timeout_ticks) begin
            phase_in       = PH_HUNT;
            tick_in        = 16'd0;
            res_valid      = 1'b1;
            res.kind       = KIND_TIMEOUT;
         end
      end else if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (byte_value == start_code[15:8]) begin
                  phase_in   = PH_HEADER;
                  hdr_idx_in = POS_SECOND;
                  sum_in     = 16'd0;
                  plen_in    = 16'd0;
                  type_in    = 8'h00;
                  second_in  = 8'h00;
               end
            end
            PH_HEADER: begin
               hdr_idx_in = hdr_idx_ff + 4'd1;
               case (hdr_idx_ff)
                  POS_SECOND: second_in = byte_value;
                  POS_TYPE: begin
                     type_in = byte_value;
                     sum_in  = sum_add;
                  end
                  POS_LEN_HI: begin
                     plen_in = {byte_value, 8'h00};
                     sum_in  = sum_add;
                  end
                  POS_LEN_LO: begin
                     sum_in     = sum_add;
                     hdr_idx_in = hdr_idx_ff;
                     if (second_ff != start_code[7:0]) begin
                        phase_in        = PH_HUNT;
                        tick_in         = 16'd0;
                        res_valid       = 1'b1;
                        res.kind        = KIND_BAD_START;
                        res.packet_type = type_ff;
                     end else if (len_full < MIN_LENGTH) begin
                        phase_in        = PH_HUNT;
                        tick_in         = 16'd0;
                        res_valid       = 1'b1;
                        res.kind        = KIND_BAD_LENGTH;
                        res.packet_type = type_ff;
                     end else begin
                        plen_in     = len_full - MIN_LENGTH;
                        remain_in   = len_full - MIN_LENGTH;
                        cks_seen_in = 1'b0;
                        phase_in    = (len_full == MIN_LENGTH) ? PH_CHECK : PH_PAYLOAD;
                     end
                  end
                  default: ;
               endcase
            end
            PH_PAYLOAD: begin
               sum_in    = sum_add;
               remain_in = remain_ff - 16'd1;
               if (remain_ff == 16'd1) begin
                  phase_in    = PH_CHECK;
                  cks_seen_in = 1'b0;
               end
               res_valid          = 1'b1;
               res.kind           = KIND_PAYLOAD;
               res.data_byte      = byte_value;
               res.packet_type    = type_ff;
               res.payload_length = plen_ff;
            end
            PH_CHECK: begin
               if (!cks_seen_ff) begin
                  cks_hi_in   = byte_value;
                  cks_seen_in = 1'b1;
               end else begin
                  phase_in           = PH_HUNT;
                  tick_in            = 16'd0;
                  res_valid          = 1'b1;
                  res.kind           = ({cks_hi_ff, byte_value} == sum_ff) ?
                                       KIND_GOOD : KIND_CHECKSUM;
                  res.packet_type    = type_ff;
                  res.payload_length = plen_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         hdr_idx_ff  <= 4'd0;
         remain_ff   <= 16'd0;
         plen_ff     <= 16'd0;
         sum_ff      <= 16'd0;
         second_ff   <= 8'h00;
         type_ff     <= 8'h00;
         cks_hi_ff   <= 8'h00;
         cks_seen_ff <= 1'b0;
         tick_ff     <= 16'd0;
      end else begin
         phase_ff    <= phase_in;
         hdr_idx_ff  <= hdr_idx_in;
         remain_ff   <= remain_in;
         plen_ff     <= plen_in;
         sum_ff      <= sum_in;
         second_ff   <= second_in;
         type_ff     <= type_in;
         cks_hi_ff   <= cks_hi_in;
         cks_seen_ff <= cks_seen_in;
         tick_ff     <= tick_in;
      end
   end

`ifndef ASSERT_OFF
   a_result_needs_transfer: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> accept)
      else $error("result raised without an input transfer");

   a_header_index_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER) |-> (hdr_idx_ff >= POS_SECOND && hdr_idx_ff <= POS_LEN_LO))
      else $error("header index out of range");

   a_frame_end_clears_ticks: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind != KIND_PAYLOAD) |=> (tick_ff == 16'd0 && phase_ff == PH_HUNT))
      else $error("frame end did not clear tick count or return to hunting");
`endif

endmodule

// ===== src/srpd_skid.sv =====
// Result register with one skid entry.
`timescale 1ns / 1ps

module srpd_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  srpd_pkg::rsp_item_type in_item,
   output logic                  full,
   srpd_rsp_if.source            rsp
);
   import srpd_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         hold_valid_ff, hold_valid_in;
   rsp_item_type out_ff, out_in;
   rsp_item_type hold_ff, hold_in;
   logic         take;

   assign take = out_valid_ff && rsp.ready;
   assign full = hold_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      hold_valid_in = hold_valid_ff;
      out_in        = out_ff;
      hold_in       = hold_ff;
      if (!out_valid_ff || take) begin
         if (hold_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = hold_ff;
            hold_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_in       = in_item;
         end
      end else if (in_valid) begin
         hold_valid_in = 1'b1;
         hold_in       = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      hold_ff <= hold_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.kind           = out_ff.kind;
   assign rsp.data_byte      = out_ff.data_byte;
   assign rsp.packet_type    = out_ff.packet_type;
   assign rsp.payload_length = out_ff.payload_length;

`ifndef ASSERT_OFF
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> !in_valid)
      else $error("new result arrived while skid entry occupied");

   a_stalled_output_kept: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp.ready) |=> out_valid_ff)
      else $error("stalled result dropped");
`endif

endmodule

// ===== src/sensor_reply_packet_deframer_core.sv =====
// Top level of the sensor reply packet deframer: CSR block, parser and result buffer.
//
//   channel  | direction | handshake          | contents
//   ---------+-----------+--------------------+------------------------------------------
//   req_ch   | in        | valid/ready        | operation (byte or tick), byte_value
//   rsp_ch   | out       | valid/ready        | kind, data_byte, packet_type, payload_length
//   csr_*    | in        | APB write/read     | start_code (0x0), timeout_ticks (0x4)
//
// One transfer per cycle while the skid entry is free; its result, if any, is registered to rsp_ch.
// The parser state registers and the result register bound the single pass per transfer.
// req_ch.ready drops only when both the result register and the skid entry are occupied.
// Reset is synchronous: it returns the parser to hunting, empties the result buffer and
// loads start_code 0xEF01 and timeout_ticks 1000.
`timescale 1ns / 1ps

module sensor_reply_packet_deframer_core (
   input  logic                              clock,
   input  logic                              reset,
   srpd_req_if.sink                          req_ch,
   srpd_rsp_if.source                        rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [srpd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [srpd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [srpd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import srpd_pkg::*;

   logic [15:0]  start_code_ff, start_code_in;
   logic [15:0]  timeout_ff, timeout_in;
   logic         csr_write;
   logic         req_accept;
   logic         skid_full;
   logic         res_valid;
   rsp_item_type res;

   // CSR access: no wait states; register index is the word address bit.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      start_code_in = start_code_ff;
      timeout_in    = timeout_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_START_CODE: start_code_in = csr_pwdata[15:0];
            REG_TIMEOUT:    timeout_in    = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_START_CODE: csr_prdata = {16'h0000, start_code_ff};
         REG_TIMEOUT:    csr_prdata = {16'h0000, timeout_ff};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff <= START_CODE_RESET;
         timeout_ff    <= TIMEOUT_RESET;
      end else begin
         start_code_ff <= start_code_in;
         timeout_ff    <= timeout_in;
      end
   end

   // Take a new transfer whenever the skid entry is free, even while the
   // result register still waits on the sink.
   assign req_ch.ready = !skid_full;
   assign req_accept   = req_ch.valid && req_ch.ready;

   // Advance the frame state and build at most one result per transfer.
   srpd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .operation    (req_ch.operation),
      .byte_value   (req_ch.byte_value),
      .start_code   (start_code_ff),
      .timeout_ticks(timeout_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   // Hold results until the sink takes them.
   srpd_skid u_skid (
      .clock   (clock),
      .reset   (reset),
      .in_valid(res_valid),
      .in_item (res),
      .full    (skid_full),
      .rsp     (rsp_ch)
   );

endmodule
